// File: rtl/dbss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbss_pkg
// Shared types and constants for the double-buffered setpoint schedule.
// ----------------------------------------------------------------------------
package dbss_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_REPEAT_FACTOR = 2'd0;
  localparam logic [1:0] CFG_HORIZON_STEPS = 2'd1;
  localparam logic [1:0] CFG_STEP_TICKS    = 2'd2;

  // Register reset values
  localparam logic [3:0]  REPEAT_FACTOR_RST = 4'd1;
  localparam logic [7:0]  HORIZON_STEPS_RST = 8'd32;
  localparam logic [15:0] STEP_TICKS_RST    = 16'd2000;

  // Item modes
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam int STAMP_W    = 32;
  localparam int OUT_JOINTS = 4;
  localparam int LEN_W      = 12;

  typedef struct packed {
    logic               mode;
    logic [31:0]        time_value;
    logic               last_point;
    logic signed [15:0] torque_0;
    logic signed [15:0] torque_1;
    logic signed [15:0] torque_2;
    logic signed [15:0] torque_3;
  } item_t;

  typedef struct packed {
    logic signed [15:0] out_torque_0;
    logic signed [15:0] out_torque_1;
    logic signed [15:0] out_torque_2;
    logic signed [15:0] out_torque_3;
    logic [31:0]        out_stamp;
  } result_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD_MUL,
    ST_LOAD_WR,
    ST_SCAN_INIT,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic clr_write;
    logic capture;
    logic load_mul;
    logic load_write;
    logic load_end;
    logic scan_init;
    logic scan_run;
    logic result_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic copy_left;
    logic scan_done;
    logic result_free;
  } status_t;

endpackage

// File: rtl/double_buffered_setpoint_schedule.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_buffered_setpoint_schedule
// Ping-pong torque schedule: loads fill the inactive bank with stamped
// entries, the last load swaps banks, queries return the nearest entry.
// ----------------------------------------------------------------------------
//  channel  | signals                              | transaction when
//  ---------+--------------------------------------+---------------------------
//  item     | item_valid, item_stall, item         | item_valid && !item_stall
//  result   | result_valid, result_stall, result   | result_valid && !result_stall
//  cfg      | cfg_valid, cfg_ready, cfg_index/data | cfg_valid && cfg_ready
//
//  After reset the entry store is swept to zero with item_stall high;
//  cfg writes are taken throughout (cfg_ready is always high).
//  A load writes copies = min(repeat_factor, room left) entries, each by a
//  stamp multiply, then a write.
//  A query scans len = min(horizon_steps*repeat_factor, BANK_DEPTH) entries
//  of the active bank through the single RAM read port, one entry a
//  cycle.
//  A finished result waits in its output register; loads proceed meanwhile,
//  a further query holds its result until the register frees.
// ----------------------------------------------------------------------------
module double_buffered_setpoint_schedule #(
  parameter int BANK_DEPTH      = 128,
  parameter int ACTUATED_JOINTS = 4,
  parameter int TORQUE_BITS     = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  dbss_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output dbss_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data
);
  import dbss_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  dbss_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_mode  (item.mode),
    .item_stall (item_stall),
    .status     (status),
    .cmd        (cmd)
  );

  dbss_datapath #(
    .BANK_DEPTH      (BANK_DEPTH),
    .ACTUATED_JOINTS (ACTUATED_JOINTS),
    .TORQUE_BITS     (TORQUE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .item         (item),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

// File: rtl/dbss_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbss_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dbss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/dbss_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbss_ctrl
// Sequencer: clearing pass, load copies, query scan and result handoff.
// ----------------------------------------------------------------------------
module dbss_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_mode,
  output logic              item_stall,
  input  dbss_pkg::status_t status,
  output dbss_pkg::cmd_t    cmd
);
  import dbss_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (status.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (item_valid) begin
          state_next = (item_mode == MODE_QUERY) ? ST_SCAN_INIT : ST_LOAD_MUL;
        end
      end
      ST_LOAD_MUL: begin
        state_next = status.copy_left ? ST_LOAD_WR : ST_IDLE;
      end
      ST_LOAD_WR:   state_next = ST_LOAD_MUL;
      ST_SCAN_INIT: state_next = ST_SCAN;
      ST_SCAN: begin
        if (status.scan_done) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.result_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // Outputs
  always_comb begin
    cmd        = '0;
    item_stall = 1'b1;
    unique case (state)
      ST_CLEAR: cmd.clr_write = 1'b1;
      ST_IDLE: begin
        item_stall  = 1'b0;
        cmd.capture = item_valid;
      end
      ST_LOAD_MUL: begin
        cmd.load_mul = status.copy_left;
        cmd.load_end = !status.copy_left;
      end
      ST_LOAD_WR:   cmd.load_write = 1'b1;
      ST_SCAN_INIT: cmd.scan_init  = 1'b1;
      ST_SCAN:      cmd.scan_run   = 1'b1;
      ST_FINISH:    cmd.result_load = status.result_free;
      default: ;
    endcase
  end

endmodule

// File: rtl/dbss_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbss_datapath
// Config registers, bank bookkeeping, entry store, scan pipeline, result reg.
// ----------------------------------------------------------------------------
module dbss_datapath #(
  parameter int BANK_DEPTH      = 128,
  parameter int ACTUATED_JOINTS = 4,
  parameter int TORQUE_BITS     = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  dbss_pkg::cmd_t    cmd,
  output dbss_pkg::status_t status,
  input  dbss_pkg::item_t   item,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              result_stall,
  output logic              result_valid,
  output dbss_pkg::result_t result
);
  import dbss_pkg::*;

  localparam int IDX_W  = $clog2(BANK_DEPTH + 1);
  localparam int DEPTH  = 2 * BANK_DEPTH;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int TW     = ACTUATED_JOINTS * TORQUE_BITS;
  localparam int RAM_W  = STAMP_W + TW;
  localparam int PROD_W = IDX_W + 16;
  localparam logic [IDX_W-1:0]  BANK_IDX  = IDX_W'(BANK_DEPTH);
  localparam logic [ADDR_W-1:0] BANK_BASE = ADDR_W'(BANK_DEPTH);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  // Configuration registers
  logic [3:0]  repeat_factor;
  logic [7:0]  horizon_steps;
  logic [15:0] step_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_factor <= REPEAT_FACTOR_RST;
      horizon_steps <= HORIZON_STEPS_RST;
      step_ticks    <= STEP_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REPEAT_FACTOR: repeat_factor <= cfg_data[3:0];
        CFG_HORIZON_STEPS: horizon_steps <= cfg_data[7:0];
        CFG_STEP_TICKS:    step_ticks    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Captured item
  logic [31:0]    q_time;
  logic           q_last;
  logic [TW-1:0]  q_word;
  logic [TW-1:0]  in_word;
  logic [15:0]    in_torque [OUT_JOINTS];

  assign in_torque[0] = item.torque_0;
  assign in_torque[1] = item.torque_1;
  assign in_torque[2] = item.torque_2;
  assign in_torque[3] = item.torque_3;

  // Keep the low TORQUE_BITS of each actuated joint
  always_comb begin
    for (int j = 0; j < ACTUATED_JOINTS; j++) begin
      in_word[j*TORQUE_BITS +: TORQUE_BITS] = in_torque[j][TORQUE_BITS-1:0];
    end
  end

  // Bank bookkeeping
  logic             active_bank;
  logic             batch_open;
  logic [31:0]      batch_time;
  logic [IDX_W-1:0] write_index;
  logic [3:0]       rep_count;
  logic [PROD_W-1:0] prod;
  logic [LEN_W-1:0] len_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_bank <= 1'b0;
      batch_open  <= 1'b0;
      batch_time  <= '0;
      write_index <= '0;
      rep_count   <= '0;
    end else begin
      if (cmd.capture) begin
        rep_count <= repeat_factor;
        if (item.mode == MODE_LOAD && !batch_open) begin
          batch_open  <= 1'b1;
          batch_time  <= item.time_value;
          write_index <= '0;
        end
      end else if (cmd.load_write) begin
        write_index <= write_index + 1'b1;
        rep_count   <= rep_count - 1'b1;
      end else if (cmd.load_end && q_last) begin
        active_bank <= ~active_bank;
        batch_open  <= 1'b0;
        write_index <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      q_time   <= item.time_value;
      q_last   <= item.last_point;
      q_word   <= in_word;
      len_prod <= LEN_W'(horizon_steps * repeat_factor);
    end
    if (cmd.load_mul) begin
      prod <= PROD_W'(write_index * step_ticks);
    end
  end

  assign status.copy_left = (rep_count != '0) && (write_index < BANK_IDX);

  // Saturating stamp of the entry being written
  logic [STAMP_W:0]   stamp_sum;
  logic [STAMP_W-1:0] stamp_sat;

  assign stamp_sum = {1'b0, batch_time} + (STAMP_W + 1)'(prod);
  assign stamp_sat = stamp_sum[STAMP_W] ? '1 : stamp_sum[STAMP_W-1:0];

  // Clearing pass address
  logic [ADDR_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_write) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  assign status.clr_last = (clr_addr == LAST_ADDR);

  // Entry store
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [RAM_W-1:0]  wr_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [RAM_W-1:0]  rd_data;
  logic [ADDR_W-1:0] inactive_base;
  logic [ADDR_W-1:0] active_base;

  assign inactive_base = active_bank ? '0 : BANK_BASE;
  assign active_base   = active_bank ? BANK_BASE : '0;

  always_comb begin
    wr_en   = cmd.clr_write || cmd.load_write;
    wr_addr = cmd.clr_write ? clr_addr : inactive_base + ADDR_W'(write_index);
    wr_data = cmd.clr_write ? '0 : {stamp_sat, q_word};
  end

  dbss_ram #(
    .WIDTH (RAM_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Scan: issue, RAM read, distance, compare
  logic [IDX_W-1:0]   scan_idx;
  logic [IDX_W-1:0]   scan_len;
  logic               issue;
  logic               v1;
  logic               v2;
  logic [STAMP_W-1:0] rd_stamp;
  logic [STAMP_W-1:0] s2_diff;
  logic [STAMP_W-1:0] s2_stamp;
  logic [TW-1:0]      s2_word;
  logic               found;
  logic [STAMP_W-1:0] best_diff;
  logic [STAMP_W-1:0] best_stamp;
  logic [TW-1:0]      best_word;

  assign issue    = cmd.scan_run && (scan_idx != scan_len);
  assign rd_addr  = active_base + ADDR_W'(scan_idx);
  assign rd_stamp = rd_data[RAM_W-1 -: STAMP_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      scan_idx <= '0;
      scan_len <= '0;
      found    <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      if (cmd.scan_init) begin
        scan_idx <= '0;
        scan_len <= (len_prod > LEN_W'(BANK_DEPTH)) ? BANK_IDX : IDX_W'(len_prod);
        found    <= 1'b0;
      end else begin
        if (issue) scan_idx <= scan_idx + 1'b1;
        if (v2 && (!found || s2_diff < best_diff)) found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    // Absolute distance of the fetched stamp
    if (v1) begin
      s2_diff  <= (rd_stamp >= q_time) ? rd_stamp - q_time : q_time - rd_stamp;
      s2_stamp <= rd_stamp;
      s2_word  <= rd_data[TW-1:0];
    end
    // Strictly nearer wins; the first of equals is kept
    if (cmd.scan_init) begin
      best_stamp <= '0;
      best_word  <= '0;
    end else if (v2 && (!found || s2_diff < best_diff)) begin
      best_diff  <= s2_diff;
      best_stamp <= s2_stamp;
      best_word  <= s2_word;
    end
  end

  assign status.scan_done = (scan_idx == scan_len) && !v1 && !v2;

  // Result register
  logic [15:0] out_tq [OUT_JOINTS];

  for (genvar j = 0; j < OUT_JOINTS; j++) begin : g_out
    if (j < ACTUATED_JOINTS) begin : g_act
      assign out_tq[j] = 16'(signed'(best_word[j*TORQUE_BITS +: TORQUE_BITS]));
    end else begin : g_zero
      assign out_tq[j] = '0;
    end
  end

  assign status.result_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.result_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      result.out_torque_0 <= out_tq[0];
      result.out_torque_1 <= out_tq[1];
      result.out_torque_2 <= out_tq[2];
      result.out_torque_3 <= out_tq[3];
      result.out_stamp    <= best_stamp;
    end
  end

endmodule

// File: rtl/dbss_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbss_checker
// Port-level checks on the setpoint schedule, bound to the top level.
// ----------------------------------------------------------------------------
module dbss_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_stall,
  input dbss_pkg::item_t   item,
  input logic              result_valid,
  input logic              result_stall,
  input dbss_pkg::result_t result
);
  import dbss_pkg::*;

  // Store is being cleared right after reset
  a_stall_after_reset: assert property (@(posedge clk) rst |=> item_stall)
    else $error("item accepted during clearing pass");

  // Every accepted transaction leaves the block busy in the cycle after it
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> item_stall)
    else $error("item accepted back to back");

  // A load never produces a result
  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall && item.mode == MODE_LOAD && !result_valid)
      |=> !result_valid)
    else $error("result after load transaction");

  // A result appears only while the input side is busy
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(item_stall))
    else $error("result appeared while idle");

  // Stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(result)))
    else $error("stalled result changed");

endmodule

bind double_buffered_setpoint_schedule dbss_checker u_checker (.*);
